FILE: rtl/unicycle_steering_law_defines.svh
// Assertion macros for the steering law block.
`ifndef UNICYCLE_STEERING_LAW_DEFINES_SVH
`define UNICYCLE_STEERING_LAW_DEFINES_SVH
`ifndef SYNTH
`define USL_ASSERT(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("steering law assertion failed");
`define USL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("steering law assertion failed");
`define USL_ASSERT_RST(lbl, clk, rst_n, cons) \
    lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
        else $error("steering law reset assertion failed");
`else
`define USL_ASSERT(lbl, clk, rst_n, cond)
`define USL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define USL_ASSERT_RST(lbl, clk, rst_n, cons)
`endif
`endif

FILE: rtl/usl_pkg.sv
// Shared constants, types and the arctangent table of the steering law block.
package usl_pkg;
    localparam int CORDIC_STAGES = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int N_STAGES = (CORDIC_STAGES < ANG_TABLE_LEN) ? CORDIC_STAGES : ANG_TABLE_LEN;

    localparam int VW = 36;   // vectoring datapath width
    localparam int RW = 34;   // rotation datapath width
    localparam int ZW = 26;   // rotation angle width

    localparam logic [23:0] HALF_TURN_24 = 24'h800000;
    localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
    localparam logic signed [RW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [15:0] PI_Q13 = 16'sd25736;
    localparam logic [14:0] Q15_MAX = 15'd32767;

    localparam logic [1:0] REG_ARRIVE = 2'd0;
    localparam logic [1:0] REG_DGAIN  = 2'd1;
    localparam logic [1:0] REG_HGAIN  = 2'd2;

    typedef struct packed {
        logic        steer;
        logic [15:0] heading;
    } t_vside;

    typedef struct packed {
        logic              stop;
        logic              e_ok;
        logic signed [15:0] yaw;
        logic [14:0]       term;
    } t_rside;

    function automatic logic [21:0] atan_entry(input int i);
        logic [21:0] v;
        case (i)
            0: v = 22'd2097152;  1: v = 22'd1238021;  2: v = 22'd654136;
            3: v = 22'd332050;   4: v = 22'd166669;   5: v = 22'd83416;
            6: v = 22'd41718;    7: v = 22'd20860;    8: v = 22'd10430;
            9: v = 22'd5215;     10: v = 22'd2608;    11: v = 22'd1304;
            12: v = 22'd652;     13: v = 22'd326;     14: v = 22'd163;
            15: v = 22'd81;      16: v = 22'd41;      17: v = 22'd20;
            18: v = 22'd10;      19: v = 22'd5;       20: v = 22'd3;
            21: v = 22'd1;       22: v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction
endpackage

FILE: rtl/usl_vector.sv
// Pipelined CORDIC vectoring: magnitude and bearing of the position error.
module usl_vector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [31:0]                 i_ex,
    input  logic signed [31:0]                 i_ey,
    input  usl_pkg::t_vside                    i_side,
    output logic                               o_valid,
    output logic signed [usl_pkg::VW-1:0]      o_x,
    output logic [23:0]                        o_z,
    output usl_pkg::t_vside                    o_side
);
    localparam int N = usl_pkg::N_STAGES;

    logic                          r_v [0:N];
    logic signed [usl_pkg::VW-1:0] r_x [0:N];
    logic signed [usl_pkg::VW-1:0] r_y [0:N];
    logic [23:0]                   r_z [0:N];
    usl_pkg::t_vside               r_s [0:N];

    // fold the left half plane onto the right one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_ex < 0) begin
                r_x[0] <= -usl_pkg::VW'(i_ex);
                r_y[0] <= -usl_pkg::VW'(i_ey);
                r_z[0] <= usl_pkg::HALF_TURN_24;
            end else begin
                r_x[0] <= usl_pkg::VW'(i_ex);
                r_y[0] <= usl_pkg::VW'(i_ey);
                r_z[0] <= 24'd0;
            end
            r_s[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [usl_pkg::VW-1:0] xs, ys;
        logic [23:0]                   at;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        assign at = 24'(usl_pkg::atan_entry(k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[k] > 0) begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + at;
                end else begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - at;
                end
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_x     = r_x[N];
    assign o_z     = r_z[N];
    assign o_side  = r_s[N];
endmodule

FILE: rtl/usl_rotate.sv
// Pipelined CORDIC rotation: cosine of the heading error.
module usl_rotate (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_valid,
    input  logic signed [15:0]                 i_e,
    input  usl_pkg::t_rside                    i_side,
    output logic                               o_valid,
    output logic signed [usl_pkg::RW-1:0]      o_x,
    output usl_pkg::t_rside                    o_side
);
    localparam int N = usl_pkg::N_STAGES;

    logic                          r_v [0:N];
    logic signed [usl_pkg::RW-1:0] r_x [0:N];
    logic signed [usl_pkg::RW-1:0] r_y [0:N];
    logic signed [usl_pkg::ZW-1:0] r_z [0:N];
    usl_pkg::t_rside               r_s [0:N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= usl_pkg::INV_GAIN_Q30;
            r_y[0] <= '0;
            r_z[0] <= usl_pkg::ZW'($signed({i_e, 8'd0}));
            r_s[0] <= i_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic signed [usl_pkg::RW-1:0] xs, ys;
        logic signed [usl_pkg::ZW-1:0] at;
        assign xs = r_x[k] >>> k;
        assign ys = r_y[k] >>> k;
        assign at = usl_pkg::ZW'(usl_pkg::atan_entry(k));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_z[k] >= 0) begin
                    r_x[k+1] <= r_x[k] - ys;
                    r_y[k+1] <= r_y[k] + xs;
                    r_z[k+1] <= r_z[k] - at;
                end else begin
                    r_x[k+1] <= r_x[k] + ys;
                    r_y[k+1] <= r_y[k] - xs;
                    r_z[k+1] <= r_z[k] + at;
                end
                r_s[k+1] <= r_s[k];
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_x     = r_x[N];
    assign o_side  = r_s[N];
endmodule

FILE: rtl/unicycle_steering_law.sv
// Top level of the unicycle go-to-goal steering law pipeline.
//
//  channel  direction  handshake          payload
//  in       sink       i_valid / o_stall  target_x/y, pos_x/y, heading, steer_enable
//  out      source     o_valid / i_stall  forward_cmd, yaw_rate_cmd
//  cfg      sink       i_cfg_we           i_cfg_idx, i_cfg_data
//
// One item per cycle while the sink does not stall; the two CORDIC pipelines
// have one stage per iteration.
// Reset clears all valid bits and loads the register reset values.
// The whole pipeline holds only when a result waits in the output register
// and the sink stalls; bubbles travel on as empty stages.
`include "unicycle_steering_law_defines.svh"

module unicycle_steering_law (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_target_x,
    input  logic signed [31:0] i_target_y,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [15:0] i_heading,
    input  logic               i_steer_enable,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [14:0]        o_forward_cmd,
    output logic signed [15:0] o_yaw_rate_cmd,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // configuration registers
    logic [15:0] r_arrive, r_dgain, r_hgain;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrive <= 16'd3932;
            r_dgain  <= 16'd6144;
            r_hgain  <= 16'd5734;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                usl_pkg::REG_ARRIVE: r_arrive <= i_cfg_data;
                usl_pkg::REG_DGAIN:  r_dgain  <= i_cfg_data;
                usl_pkg::REG_HGAIN:  r_hgain  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage 0: saturated position error
    logic signed [32:0] dx, dy;
    logic signed [31:0] n_ex, n_ey;
    assign dx = 33'(i_target_x) - 33'(i_pos_x);
    assign dy = 33'(i_target_y) - 33'(i_pos_y);
    always_comb begin
        n_ex = (dx[32] != dx[31]) ? (dx[32] ? 32'sh80000000 : 32'sh7fffffff) : dx[31:0];
        n_ey = (dy[32] != dy[31]) ? (dy[32] ? 32'sh80000000 : 32'sh7fffffff) : dy[31:0];
    end

    logic               r_v0;
    logic signed [31:0] r_ex, r_ey;
    usl_pkg::t_vside    r_s0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= n_ex;
            r_ey <= n_ey;
            r_s0 <= '{steer: i_steer_enable, heading: i_heading};
        end
    end

    logic                                vec_v;
    logic signed [usl_pkg::VW-1:0]       vec_x;
    logic [23:0]                         vec_z;
    usl_pkg::t_vside                     vec_s;
    usl_pkg::t_vside                     vec_s_in;
    assign vec_s_in = r_s0;

    usl_vector u_vector (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v0),
        .i_ex    (r_ex),
        .i_ey    (r_ey),
        .i_side  (vec_s_in),
        .o_valid (vec_v),
        .o_x     (vec_x),
        .o_z     (vec_z),
        .o_side  (vec_s)
    );

    // stage A: gain-compensate the magnitude, round the bearing
    logic               r_va;
    logic [49:0]        r_magp;
    logic [15:0]        r_bear;
    usl_pkg::t_vside    r_sa;
    logic [33:0]        xpos;
    logic [24:0]        zr;
    assign xpos = (vec_x < 0) ? 34'd0 : vec_x[33:0];
    assign zr   = {1'b0, vec_z} + 25'd128;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (en) begin
            r_va <= vec_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_magp <= xpos * usl_pkg::INV_GAIN_Q16;
            r_bear <= zr[23:8];
            r_sa   <= vec_s;
        end
    end

    // stage B: distance, stop band, heading error
    logic               r_vb;
    logic [33:0]        r_dist;
    logic signed [15:0] r_e;
    logic               r_stopb;
    logic [49:0]        magr;
    logic [33:0]        n_dist;
    assign magr   = r_magp + 50'd32768;
    assign n_dist = magr[49:16];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (en) begin
            r_vb <= r_va;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dist  <= n_dist;
            r_e     <= r_bear - r_sa.heading;
            r_stopb <= !r_sa.steer || (n_dist <= 34'(r_arrive));
        end
    end

    // stage C: first gain products
    logic               r_vc;
    logic signed [32:0] r_ge;
    logic [49:0]        r_dt;
    logic signed [15:0] r_ec;
    logic               r_stopc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vc <= 1'b0;
        end else if (en) begin
            r_vc <= r_vb;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ge    <= $signed({1'b0, r_hgain}) * r_e;
            r_dt    <= r_dist * r_dgain;
            r_ec    <= r_e;
            r_stopc <= r_stopb;
        end
    end

    // stage D: scale by pi, clamp the distance term
    logic               r_vd;
    logic signed [48:0] r_yp;
    logic [14:0]        r_term;
    logic signed [15:0] r_ed;
    logic               r_stopd;
    logic [36:0]        tsh;
    assign tsh = r_dt[49:13];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= 1'b0;
        end else if (en) begin
            r_vd <= r_vc;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_yp    <= r_ge * usl_pkg::PI_Q13;
            r_term  <= (tsh > 37'(usl_pkg::Q15_MAX)) ? usl_pkg::Q15_MAX : tsh[14:0];
            r_ed    <= r_ec;
            r_stopd <= r_stopc;
        end
    end

    // stage E: round and clamp the yaw rate
    logic               r_ve;
    logic signed [15:0] r_ee;
    usl_pkg::t_rside    r_se;
    logic signed [48:0] ypr;
    logic signed [23:0] ysh;
    logic signed [15:0] n_yaw;
    assign ypr = r_yp + 49'sd16777216;
    assign ysh = 24'(ypr >>> 25);
    always_comb begin
        if (ysh > 24'sd32767) begin
            n_yaw = 16'sd32767;
        end else if (ysh < -24'sd32767) begin
            n_yaw = -16'sd32767;
        end else begin
            n_yaw = ysh[15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en) begin
            r_ve <= r_vd;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ee <= r_ed;
            r_se <= '{stop: r_stopd,
                      e_ok: (r_ed > -16'sd16384) && (r_ed < 16'sd16384),
                      yaw:  n_yaw,
                      term: r_term};
        end
    end

    logic                          rot_v;
    logic signed [usl_pkg::RW-1:0] rot_x;
    usl_pkg::t_rside               rot_s;

    usl_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_ve),
        .i_e     (r_ee),
        .i_side  (r_se),
        .o_valid (rot_v),
        .o_x     (rot_x),
        .o_side  (rot_s)
    );

    // output stage: cosine, forward command, stop gating of the yaw rate
    logic signed [usl_pkg::RW-1:0] xr;
    logic signed [18:0]            csh;
    logic [14:0]                   cq;
    logic [29:0]                   fp;
    assign xr  = rot_x + 34'sd16384;
    assign csh = 19'(xr >>> 15);
    always_comb begin
        if (csh < 0) begin
            cq = 15'd0;
        end else if (csh > 19'sd32767) begin
            cq = usl_pkg::Q15_MAX;
        end else begin
            cq = csh[14:0];
        end
    end
    assign fp = rot_s.term * cq + 30'd16384;

    logic               r_ov;
    logic [14:0]        r_fwd;
    logic signed [15:0] r_yaw;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= rot_v;
        end
    end
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_fwd <= (rot_s.stop || !rot_s.e_ok) ? 15'd0 : fp[29:15];
            r_yaw <= rot_s.stop ? 16'sd0 : rot_s.yaw;
        end
    end

    assign o_valid        = r_ov;
    assign o_forward_cmd  = r_fwd;
    assign o_yaw_rate_cmd = r_yaw;

    `USL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `USL_ASSERT(a_yaw_range, i_clk, i_rst_n, !o_valid || (o_yaw_rate_cmd != 16'sh8000))
    `USL_ASSERT_RST(a_rst_empty, i_clk, i_rst_n, !o_valid)
endmodule
